FILE: rtl/core/csd_pkg.sv
`default_nettype none

package csd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned NUM_SLOTS_DEF   = 32;
  localparam int unsigned SLOT_W          = 5;
  localparam int unsigned TAG_W           = 8;
  localparam int unsigned LBA_W           = 48;
  localparam int unsigned CNT_W           = 16;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned CI_W            = 32;

  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  localparam logic [1:0] KIND_COMPLETE = 2'd0;
  localparam logic [1:0] KIND_ISSUE    = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;

  typedef enum logic {
    OP_SUBMIT,
    OP_POLL
  } op_e;

  typedef struct packed {
    logic              req_type;
    logic [TAG_W-1:0]  tag;
    logic [LBA_W-1:0]  lba;
    logic [CNT_W-1:0]  sector_count;
    logic              is_write;
    logic [ADDR_W-1:0] buffer_addr;
    logic [CI_W-1:0]   ci_snapshot;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag_res;
    logic [LBA_W-1:0]  lba_res;
    logic [CNT_W-1:0]  sector_count_res;
    logic              is_write_res;
    logic [ADDR_W-1:0] buffer_addr_res;
    logic              last;
  } res_t;

  typedef struct packed {
    op_e  op;
    req_t req;
  } cmd_t;

  // one queued request as stored in the request FIFO
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [LBA_W-1:0]  lba;
    logic [CNT_W-1:0]  sector_count;
    logic              is_write;
    logic [ADDR_W-1:0] buffer_addr;
  } qent_t;

endpackage

`default_nettype wire

FILE: rtl/core/csd_front.sv
`default_nettype none

module csd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire csd_pkg::req_t req_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output csd_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_take_i
);
  import csd_pkg::*;

  cmd_t       ent_q [2];
  cmd_t       cmd_in;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign busy_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rp_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_take_i && cmd_valid_o;

  always_comb begin
    cmd_in.req = req_i;
    cmd_in.op  = (req_i.req_type == REQ_POLL) ? OP_POLL : OP_SUBMIT;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/csd_back.sv
`default_nettype none

module csd_back #(
  parameter int unsigned QUEUE_DEPTH = csd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_SLOTS   = csd_pkg::NUM_SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire csd_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  output logic               res_valid_o,
  output csd_pkg::res_t      res_o
);
  import csd_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_COMP,
    ST_ISSUE,
    ST_FLUSH
  } state_e;

  state_e               state_q;
  cmd_t                 cmd_q;
  logic [SW-1:0]        scan_q;
  logic [NUM_SLOTS-1:0] busy_q;
  logic [QAW-1:0]       head_q, tail_q, head_d;
  logic [FW-1:0]        fill_q;
  res_t                 hold_q;
  logic                 hold_v_q;
  res_t                 res_q;
  logic                 valid_q;

  qent_t                mem [QUEUE_DEPTH];
  qent_t                rd_q;
  qent_t                wr_ent;
  logic [TAG_W-1:0]     slot_tag [NUM_SLOTS];

  logic                 q_full, scan_last;
  logic                 wr_en, comp_fire, issue_fire, new_valid;
  res_t                 new_res;
  logic                 emit;
  res_t                 emit_res;

  function automatic logic [QAW-1:0] ptr_next(input logic [QAW-1:0] p);
    ptr_next = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  assign cmd_take_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  assign q_full     = (fill_q == FW'(QUEUE_DEPTH));
  assign scan_last  = (scan_q == SW'(NUM_SLOTS - 1));
  assign wr_en      = (state_q == ST_SUBMIT) && !q_full;
  assign comp_fire  = (state_q == ST_COMP) && busy_q[scan_q]
                      && !cmd_q.req.ci_snapshot[scan_q];
  assign issue_fire = (state_q == ST_ISSUE) && (fill_q != '0) && !busy_q[scan_q];
  assign head_d     = issue_fire ? ptr_next(head_q) : head_q;

  // drain the held result when the next one arrives, or with last set at flush
  assign emit = hold_v_q && (new_valid || (state_q == ST_FLUSH));

  always_comb begin
    emit_res      = hold_q;
    emit_res.last = (state_q == ST_FLUSH);
  end

  always_comb begin
    wr_ent.tag          = cmd_q.req.tag;
    wr_ent.lba          = cmd_q.req.lba;
    wr_ent.sector_count = cmd_q.req.sector_count;
    wr_ent.is_write     = cmd_q.req.is_write;
    wr_ent.buffer_addr  = cmd_q.req.buffer_addr;
  end

  // build the result produced this cycle, if any
  always_comb begin
    new_res   = '0;
    new_valid = 1'b0;
    if (comp_fire) begin
      new_valid       = 1'b1;
      new_res.kind    = KIND_COMPLETE;
      new_res.slot    = SLOT_W'(scan_q);
      new_res.tag_res = slot_tag[scan_q];
    end else if (issue_fire) begin
      new_valid                = 1'b1;
      new_res.kind             = KIND_ISSUE;
      new_res.slot             = SLOT_W'(scan_q);
      new_res.tag_res          = rd_q.tag;
      new_res.lba_res          = rd_q.lba;
      new_res.sector_count_res = rd_q.sector_count;
      new_res.is_write_res     = rd_q.is_write;
      new_res.buffer_addr_res  = rd_q.buffer_addr;
    end else if ((state_q == ST_SUBMIT) && q_full) begin
      new_valid       = 1'b1;
      new_res.kind    = KIND_FULL;
      new_res.tag_res = cmd_q.req.tag;
    end
  end

  // request FIFO storage; read port follows the next head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= wr_ent;
    end
    rd_q <= mem[head_d];
  end

  always_ff @(posedge clk_i) begin
    if (issue_fire) begin
      slot_tag[scan_q] <= rd_q.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scan_q   <= '0;
      busy_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      hold_q   <= '0;
      hold_v_q <= 1'b0;
      res_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= emit;
      head_q  <= head_d;
      if (emit) begin
        res_q <= emit_res;
      end

      // hold one result back so the final one can carry last
      if (new_valid) begin
        hold_q   <= new_res;
        hold_v_q <= 1'b1;
      end

      if (comp_fire) begin
        busy_q[scan_q] <= 1'b0;
      end
      if (issue_fire) begin
        busy_q[scan_q] <= 1'b1;
        fill_q         <= fill_q - FW'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            scan_q  <= '0;
            state_q <= (cmd_i.op == OP_POLL) ? ST_COMP : ST_SUBMIT;
          end
        end
        ST_SUBMIT: begin
          if (!q_full) begin
            tail_q <= ptr_next(tail_q);
            fill_q <= fill_q + FW'(1);
          end
          state_q <= ST_FLUSH;
        end
        ST_COMP: begin
          if (scan_last) begin
            scan_q  <= '0;
            state_q <= ST_ISSUE;
          end else begin
            scan_q <= scan_q + SW'(1);
          end
        end
        ST_ISSUE: begin
          if ((fill_q == '0) || scan_last) begin
            state_q <= ST_FLUSH;
          end else begin
            scan_q <= scan_q + SW'(1);
          end
        end
        ST_FLUSH: begin
          hold_v_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/command_slot_dispatcher_top.sv
`default_nettype none

// Command slot dispatcher. Raise start_i with a submit or poll beat on req_i; the beat is
// taken when busy_o is low. A front stage buffers up to two beats, and a back stage runs
// them one at a time. A submit passes through dispatch, FIFO write and flush in the back
// stage, and gives a queue-full result only when the request FIFO holds QUEUE_DEPTH
// entries. A poll runs dispatch, a completion scan over every slot, an issue scan over
// the slots (stopping early once the FIFO runs dry) and flush; both scans step one slot
// per cycle. Each result appears on res_o for one cycle with res_valid_o high and must
// be taken then; the block never waits on the receiver. The last result of an item is
// registered at the end of the flush cycle with last set and shows on res_o the cycle
// after. Each result is held back in hold_q before it is registered into res_q, so
// results trail the scan.
module command_slot_dispatcher_top #(
  parameter int unsigned QUEUE_DEPTH = csd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned NUM_SLOTS   = csd_pkg::NUM_SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire csd_pkg::req_t req_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output csd_pkg::res_t      res_o
);
  import csd_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  csd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  csd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_SLOTS   (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
